// File: hdl/srs_pkg.sv
// Shared types, register codes and helper functions for the substring replace stream.
package srs_pkg;

   localparam int MaxPattern     = 8;
   localparam int MaxReplacement = 8;
   localparam int QueueDepth     = 2;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        run_last;
      logic        string_done;
      logic [15:0] replace_total;
      logic [15:0] occurrence_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [63:0] replacement_bytes;
      logic [3:0]  replacement_length;
   } cfg_type;

   // One batch of output bytes for the back end; count 0 with string_end is an empty end marker
   typedef struct packed {
      logic [7:0][7:0] data;
      logic [3:0]      count;
      logic            string_end;
      logic [15:0]     replace_total;
      logic [15:0]     occurrence_total;
   } job_type;

   function automatic logic [3:0] eff_pat_len(input logic [3:0] len);
      logic [3:0] n;
      n = len;
      if (n == 4'd0) n = 4'd1;
      if (n > 4'(MaxPattern)) n = 4'(MaxPattern);
      return n;
   endfunction

   function automatic logic [3:0] eff_rep_len(input logic [3:0] len);
      logic [3:0] n;
      n = len;
      if (n > 4'(MaxReplacement)) n = 4'(MaxReplacement);
      return n;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic hit);
      logic [15:0] r;
      r = v;
      if (hit && (v != 16'hFFFF)) r = v + 16'd1;
      return r;
   endfunction

endpackage

// File: hdl/srs_front.sv
// Front end: takes source bytes, tracks the match window and history, and builds output batches.
module srs_front (
   input  logic              clock,
   input  logic              reset,
   input  srs_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  srs_pkg::req_type  req_payload,
   input  logic              queue_full,
   output logic              job_push,
   output srs_pkg::job_type  job
);

   logic [7:0]  window_ff [8];
   logic [7:0]  window_in [8];
   logic [2:0]  pend_ff, pend_in;
   logic [7:0]  hist_ff [8];
   logic [7:0]  hist_new [8];
   logic [3:0]  fill_ff, fill_in, fill_new;
   logic [15:0] rep_ff, rep_in, rep_next;
   logic [15:0] occ_ff, occ_in, occ_next;

   logic [7:0]  win_new [8];
   logic [7:0][7:0] pat;
   logic [7:0][7:0] win_packed;
   logic [3:0]  plen, rlen, cnt, ksel, hist_off, hist_idx, rem, shift_idx;
   logic [7:0]  eq [8];
   logic [7:0]  cond;
   logic        prefix_full, match, occ_hit, accept;
   logic [3:0]  emit_count;

   assign pat       = cfg.pattern_bytes;
   assign plen      = srs_pkg::eff_pat_len(cfg.pattern_length);
   assign rlen      = srs_pkg::eff_rep_len(cfg.replacement_length);
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cnt       = {1'b0, pend_ff} + 4'd1;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         win_new[j]    = (3'(j) == pend_ff) ? req_payload.text_byte : window_ff[j];
         win_packed[j] = win_new[j];
      end
      for (int j = 0; j < 8; j++) begin
         for (int i = 0; i < 8; i++) begin
            eq[j][i] = (win_new[j] == pat[i]);
         end
      end
      // cond[k]: after k pops the remainder is a proper prefix of the pattern
      for (int k = 0; k < 8; k++) begin
         rem     = cnt - 4'(k);
         cond[k] = (rem < plen);
         for (int i = 0; i < 8; i++) begin
            if (k + i < 8) begin
               if (4'(i) < rem && !eq[k+i][i]) cond[k] = 1'b0;
            end
         end
      end
      ksel = cnt;
      for (int k = 7; k >= 0; k--) begin
         if (4'(k) < cnt && cond[k]) ksel = 4'(k);
      end
      prefix_full = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < plen && !eq[i][i]) prefix_full = 1'b0;
      end
      match = (cnt == plen) && prefix_full;

      for (int j = 0; j < 8; j++) begin
         shift_idx = 4'(j) + ksel;
         window_in[j] = (shift_idx < 4'd8) ? win_new[shift_idx[2:0]] : win_new[j];
      end
   end

   // overlapping occurrence check over the last source bytes
   always_comb begin
      for (int j = 0; j < 7; j++) begin
         hist_new[j] = hist_ff[j+1];
      end
      hist_new[7] = req_payload.text_byte;
      fill_new    = (fill_ff < 4'd8) ? fill_ff + 4'd1 : fill_ff;
      hist_off    = 4'd8 - plen;
      occ_hit     = (fill_new >= plen);
      for (int i = 0; i < 8; i++) begin
         hist_idx = hist_off + 4'(i);
         if (4'(i) < plen && hist_new[hist_idx[2:0]] != pat[i]) occ_hit = 1'b0;
      end
   end

   always_comb begin
      occ_next = srs_pkg::sat_inc(occ_ff, occ_hit);
      rep_next = srs_pkg::sat_inc(rep_ff, match);
      if (match) begin
         emit_count = rlen;
         pend_in    = 3'd0;
      end else begin
         emit_count = req_payload.string_end ? cnt : ksel;
         pend_in    = 3'(cnt - ksel);
      end
      if (req_payload.string_end) begin
         pend_in = 3'd0;
         fill_in = 4'd0;
         rep_in  = 16'd0;
         occ_in  = 16'd0;
      end else begin
         fill_in = fill_new;
         rep_in  = rep_next;
         occ_in  = occ_next;
      end
      job.data             = match ? cfg.replacement_bytes : win_packed;
      job.count            = emit_count;
      job.string_end       = req_payload.string_end;
      job.replace_total    = rep_next;
      job.occurrence_total = occ_next;
      job_push = accept && (req_payload.string_end || emit_count != 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
         fill_ff <= 4'd0;
         rep_ff  <= 16'd0;
         occ_ff  <= 16'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         fill_ff <= fill_in;
         rep_ff  <= rep_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 8; j++) begin
            window_ff[j] <= window_in[j];
            hist_ff[j]   <= hist_new[j];
         end
      end
   end

endmodule

// File: hdl/srs_queue.sv
// Two-entry queue of output batches between the front and back ends.
module srs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  srs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output srs_pkg::job_type head_job
);

   localparam int PtrW = $clog2(srs_pkg::QueueDepth);

   srs_pkg::job_type entry_ff [srs_pkg::QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]    used_ff, used_in;

   assign full       = (used_ff == (PtrW+1)'(srs_pkg::QueueDepth));
   assign head_valid = (used_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      used_in = used_ff;
      if (push && !pop) used_in = used_ff + (PtrW+1)'(1);
      if (pop && !push) used_in = used_ff - (PtrW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// File: hdl/srs_back.sv
// Back end: unpacks each batch into result transfers through an output register.
module srs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  srs_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srs_pkg::rsp_type rsp_payload
);

   logic             valid_ff;
   srs_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0]       idx_ff;
   logic             load, last;

   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign last      = (head_job.count == 4'd0) || ({1'b0, idx_ff} == head_job.count - 4'd1);
   assign pop       = load && last;
   assign rsp_valid = valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rsp_in.byte_valid       = (head_job.count != 4'd0);
      rsp_in.out_byte         = rsp_in.byte_valid ? head_job.data[idx_ff] : 8'd0;
      rsp_in.run_last         = last;
      rsp_in.string_done      = last && head_job.string_end;
      rsp_in.replace_total    = rsp_in.string_done ? head_job.replace_total : 16'd0;
      rsp_in.occurrence_total = rsp_in.string_done ? head_job.occurrence_total : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last ? 3'd0 : idx_ff + 3'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

endmodule

// File: hdl/substring_replace_stream_top.sv
// Top level of the streaming substring find-and-replace block.
// A source byte is accepted whenever the two-entry batch queue has room, so the front end
// takes at most one byte per cycle. The back end then sends the byte's results one per cycle
// while rsp_ready allows, through its output register. The first result passes through the
// queue entry and then the output register. A byte may cause no result (held in the window),
// the bytes it pushes out of the window, replacement_length results (a completed match) or at
// most eight (a flush). The input stalls only while the queue is full. Configuration writes
// are registered and take effect in the cycle after the write; they are accepted every cycle.
module substring_replace_stream_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srs_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   srs_pkg::cfg_type cfg_ff;
   srs_pkg::job_type push_job, head_job;
   logic             job_push, queue_full, head_valid, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes      <= 64'd0;
         cfg_ff.pattern_length     <= 4'd1;
         cfg_ff.replacement_bytes  <= 64'd0;
         cfg_ff.replacement_length <= 4'd0;
      end else if (csr_valid) begin
         unique case (srs_pkg::csr_index_type'(csr_index))
            srs_pkg::REG_PATTERN_BYTES:      cfg_ff.pattern_bytes      <= csr_wdata;
            srs_pkg::REG_PATTERN_LENGTH:     cfg_ff.pattern_length     <= csr_wdata[3:0];
            srs_pkg::REG_REPLACEMENT_BYTES:  cfg_ff.replacement_bytes  <= csr_wdata;
            srs_pkg::REG_REPLACEMENT_LENGTH: cfg_ff.replacement_length <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   srs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job         (push_job)
   );

   srs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   srs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a batch is only built when the queue can take it
   assert property (@(posedge clock) disable iff (reset) job_push |-> !queue_full)
      else $error("batch pushed into full queue");

   // an empty end marker always closes the string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.byte_valid) |-> (rsp_payload.string_done && rsp_payload.run_last))
      else $error("empty marker without string end");

   // totals only travel with the final transfer of a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.string_done) |->
         (rsp_payload.replace_total == 16'd0 && rsp_payload.occurrence_total == 16'd0))
      else $error("totals outside string end");

   // nothing is offered in the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule
